// ----- design/ascii_unsigned_number_parser_core_defines.svh -----
// Assertion macros shared by the ASCII unsigned number parser RTL.
`ifndef ASCII_UNSIGNED_NUMBER_PARSER_CORE_DEFINES_SVH
`define ASCII_UNSIGNED_NUMBER_PARSER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ANUP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ANUP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/anup_pkg.sv -----
// Types, codes and helper functions of the ASCII unsigned number parser.
`timescale 1ns / 1ps

package anup_pkg;

   localparam int unsigned DATA_WIDTH = 64;
   localparam int unsigned CHAR_WIDTH = 8;
   localparam int unsigned STATUS_WIDTH = 2;
   localparam int unsigned KW_WIDTH = 3;

   localparam logic [STATUS_WIDTH-1:0] ST_ACCEPT = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_REJECT = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_RANDOM = 2'd2;

   localparam logic [0:0] REG_MIN_VALUE = 1'b0;
   localparam logic [0:0] REG_MAX_VALUE = 1'b1;

   localparam logic [KW_WIDTH-1:0] KW_SHORT_LEN = 3'd4;
   localparam logic [KW_WIDTH-1:0] KW_LONG_LEN = 3'd6;

   typedef enum logic [4:0] {
      PH_SPACE  = 5'b00001,
      PH_ZERO   = 5'b00010,
      PH_PREFIX = 5'b00100,
      PH_DIGITS = 5'b01000,
      PH_JUNK   = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      RX_DEC = 2'd0,
      RX_OCT = 2'd1,
      RX_HEX = 2'd2
   } radix_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } digit_type;

   function automatic logic [CHAR_WIDTH-1:0] kw_letter(input logic [KW_WIDTH-1:0] idx);
      logic [CHAR_WIDTH-1:0] letter;
      case (idx)
         3'd0:    letter = "r";
         3'd1:    letter = "a";
         3'd2:    letter = "n";
         3'd3:    letter = "d";
         3'd4:    letter = "o";
         3'd5:    letter = "m";
         default: letter = 8'd0;
      endcase
      return letter;
   endfunction

   function automatic digit_type hex_digit(input logic [CHAR_WIDTH-1:0] c);
      digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      if (c inside {["0":"9"]}) begin
         d.value = c[3:0];
      end else if (c inside {["a":"f"], ["A":"F"]}) begin
         d.value = 4'(c[2:0] + 3'd1) + 4'd8;
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

   function automatic logic digit_in_radix(input digit_type d, input radix_type rx);
      logic ok;
      case (rx)
         RX_DEC:  ok = d.valid && (d.value <= 4'd9);
         RX_OCT:  ok = d.valid && (d.value <= 4'd7);
         RX_HEX:  ok = d.valid;
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

endpackage

// ----- design/ascii_unsigned_number_parser_core.sv -----
// Top level of the ASCII unsigned number parser with automatic base detection.
`timescale 1ns / 1ps

// The block takes one character per transaction and, on the zero byte, returns
// one result transaction with a status (accepted, rejected or random keyword)
// and the parsed value, zero unless accepted; other bytes return nothing. Each
// character waits in the input register, from which the parse logic, a single
// shift-and-add on the accumulator, updates the parse state registers, so a
// character can be taken in every cycle while no zero byte is held back there,
// and the result of a string is loaded into the output register as its zero byte
// leaves the input register. A zero byte waits in the input register only while
// an earlier result still sits unclaimed in the output register. The limits may
// be written only while no string is in flight.
`include "ascii_unsigned_number_parser_core_defines.svh"

module ascii_unsigned_number_parser_core #(
   parameter int unsigned VALUE_WIDTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [anup_pkg::CHAR_WIDTH-1:0]      req_char_code,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [anup_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output logic [anup_pkg::DATA_WIDTH-1:0]      rsp_value,
   input  logic                                 csr_write_enable,
   input  logic [0:0]                           csr_index,
   input  logic [anup_pkg::DATA_WIDTH-1:0]      csr_write_data
);

   import anup_pkg::*;

   localparam int unsigned SUM_WIDTH = VALUE_WIDTH + 4;

   logic                        s1_valid_ff, s1_valid_in;
   logic [CHAR_WIDTH-1:0]       s1_char_ff;
   logic                        s1_term;
   logic                        s1_go;
   logic                        s1_fire;
   logic                        req_accept;

   logic [DATA_WIDTH-1:0]       min_ff, max_ff;

   phase_type                   phase_ff, phase_in;
   radix_type                   radix_ff, radix_in;
   logic [VALUE_WIDTH-1:0]      acc_ff, acc_in;
   logic                        ovf_ff, ovf_in;
   logic                        sign_ff, sign_in;
   logic                        junk_ff, junk_in;
   logic                        digit_seen_ff, digit_seen_in;
   logic [KW_WIDTH-1:0]         kw_prog_ff, kw_prog_in;
   logic                        kw_alive_ff, kw_alive_in;

   logic                        out_valid_ff, out_valid_in;
   logic [STATUS_WIDTH-1:0]     out_status_ff, out_status_in;
   logic [DATA_WIDTH-1:0]       out_value_ff, out_value_in;

   logic [CHAR_WIDTH-1:0]       lower_char;
   digit_type                   digit;
   radix_type                   acc_radix;
   logic [SUM_WIDTH-1:0]        acc_wide;
   logic [SUM_WIDTH-1:0]        acc_scaled;
   logic [SUM_WIDTH-1:0]        acc_sum;
   logic                        acc_ovf;
   logic [VALUE_WIDTH-1:0]      acc_new;
   logic [DATA_WIDTH-1:0]       acc_ext;

   // Input register: a zero byte may only leave it when the output register is free.
   assign s1_term    = (s1_char_ff == '0);
   assign s1_go      = !(s1_term && out_valid_ff && rsp_stall);
   assign s1_fire    = s1_valid_ff && s1_go;
   assign req_stall  = s1_valid_ff && !s1_go;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_char_ff <= req_char_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= '1;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_MIN_VALUE: min_ff <= csr_write_data;
            REG_MAX_VALUE: max_ff <= csr_write_data;
            default:       ;
         endcase
      end
   end

   // Digit decode and one multiply-by-base step built from shifts and adds.
   assign lower_char = (s1_char_ff inside {["A":"Z"]}) ? s1_char_ff + 8'd32 : s1_char_ff;
   assign digit      = hex_digit(s1_char_ff);

   always_comb begin
      case (phase_ff)
         PH_SPACE:  acc_radix = RX_DEC;
         PH_PREFIX: acc_radix = RX_HEX;
         default:   acc_radix = radix_ff;
      endcase
   end

   assign acc_wide = SUM_WIDTH'(acc_ff);

   always_comb begin
      case (acc_radix)
         RX_OCT:  acc_scaled = acc_wide << 3;
         RX_HEX:  acc_scaled = acc_wide << 4;
         default: acc_scaled = (acc_wide << 3) + (acc_wide << 1);
      endcase
   end

   assign acc_sum = acc_scaled + SUM_WIDTH'(digit.value);
   assign acc_ovf = ovf_ff || (acc_sum[SUM_WIDTH-1:VALUE_WIDTH] != '0);
   assign acc_new = acc_ovf ? '1 : acc_sum[VALUE_WIDTH-1:0];
   assign acc_ext = DATA_WIDTH'(acc_ff);

   always_comb begin
      phase_in      = phase_ff;
      radix_in      = radix_ff;
      acc_in        = acc_ff;
      ovf_in        = ovf_ff;
      sign_in       = sign_ff;
      junk_in       = junk_ff;
      digit_seen_in = digit_seen_ff;
      kw_prog_in    = kw_prog_ff;
      kw_alive_in   = kw_alive_ff;
      if (s1_fire && s1_term) begin
         phase_in      = PH_SPACE;
         radix_in      = RX_DEC;
         acc_in        = '0;
         ovf_in        = 1'b0;
         sign_in       = 1'b0;
         junk_in       = 1'b0;
         digit_seen_in = 1'b0;
         kw_prog_in    = '0;
         kw_alive_in   = 1'b1;
      end else if (s1_fire) begin
         if (kw_alive_ff) begin
            if ((kw_prog_ff < KW_LONG_LEN) && (lower_char == kw_letter(kw_prog_ff))) begin
               kw_prog_in = kw_prog_ff + 3'd1;
            end else begin
               kw_alive_in = 1'b0;
            end
         end
         if (s1_char_ff == "+" || s1_char_ff == "-") begin
            sign_in = 1'b1;
         end
         case (phase_ff)
            PH_SPACE: begin
               if (s1_char_ff == 8'd32 || s1_char_ff inside {[8'd9:8'd13]}) begin
                  phase_in = PH_SPACE;
               end else if (s1_char_ff == "0") begin
                  phase_in      = PH_ZERO;
                  radix_in      = RX_OCT;
                  acc_in        = '0;
                  digit_seen_in = 1'b1;
               end else if (s1_char_ff inside {["1":"9"]}) begin
                  phase_in      = PH_DIGITS;
                  radix_in      = RX_DEC;
                  acc_in        = acc_new;
                  ovf_in        = acc_ovf;
                  digit_seen_in = 1'b1;
               end else begin
                  phase_in = PH_JUNK;
                  junk_in  = 1'b1;
               end
            end
            PH_ZERO: begin
               if (s1_char_ff == "x" || s1_char_ff == "X") begin
                  phase_in = PH_PREFIX;
               end else if (s1_char_ff inside {["0":"7"]}) begin
                  phase_in      = PH_DIGITS;
                  acc_in        = acc_new;
                  ovf_in        = acc_ovf;
                  digit_seen_in = 1'b1;
               end else begin
                  phase_in = PH_JUNK;
                  junk_in  = 1'b1;
               end
            end
            PH_PREFIX: begin
               if (digit.valid) begin
                  phase_in      = PH_DIGITS;
                  radix_in      = RX_HEX;
                  acc_in        = acc_new;
                  ovf_in        = acc_ovf;
                  digit_seen_in = 1'b1;
               end else begin
                  phase_in = PH_JUNK;
                  junk_in  = 1'b1;
               end
            end
            PH_DIGITS: begin
               if (digit_in_radix(digit, radix_ff)) begin
                  acc_in        = acc_new;
                  ovf_in        = acc_ovf;
                  digit_seen_in = 1'b1;
               end else begin
                  phase_in = PH_JUNK;
                  junk_in  = 1'b1;
               end
            end
            default: begin
               phase_in = PH_JUNK;
               junk_in  = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_SPACE;
         radix_ff      <= RX_DEC;
         acc_ff        <= '0;
         ovf_ff        <= 1'b0;
         sign_ff       <= 1'b0;
         junk_ff       <= 1'b0;
         digit_seen_ff <= 1'b0;
         kw_prog_ff    <= '0;
         kw_alive_ff   <= 1'b1;
      end else begin
         phase_ff      <= phase_in;
         radix_ff      <= radix_in;
         acc_ff        <= acc_in;
         ovf_ff        <= ovf_in;
         sign_ff       <= sign_in;
         junk_ff       <= junk_in;
         digit_seen_ff <= digit_seen_in;
         kw_prog_ff    <= kw_prog_in;
         kw_alive_ff   <= kw_alive_in;
      end
   end

   // Verdict on the zero byte, taken from the state the string has left.
   always_comb begin
      out_status_in = ST_REJECT;
      out_value_in  = '0;
      if (!sign_ff && kw_alive_ff &&
          (kw_prog_ff == KW_SHORT_LEN || kw_prog_ff == KW_LONG_LEN)) begin
         out_status_in = ST_RANDOM;
      end else if (!sign_ff && !ovf_ff && !junk_ff && digit_seen_ff &&
                   phase_ff != PH_PREFIX && phase_ff != PH_JUNK &&
                   acc_ext >= min_ff && acc_ext <= max_ff) begin
         out_status_in = ST_ACCEPT;
         out_value_in  = acc_ext;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (s1_fire && s1_term) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (s1_fire && s1_term) begin
         out_status_ff <= out_status_in;
         out_value_ff  <= out_value_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_status = out_status_ff;
   assign rsp_value  = out_value_ff;

   `ANUP_ASSERT_SAME(a_reject_value_zero, clock, reset,
      out_valid_ff && out_status_ff != ST_ACCEPT, out_value_ff == '0,
      "A rejected or keyword result carries a nonzero value.")
   `ANUP_ASSERT_SAME(a_accept_in_range, clock, reset,
      out_valid_ff && out_status_ff == ST_ACCEPT,
      out_value_ff >= min_ff && out_value_ff <= max_ff,
      "An accepted value lies outside the configured limits.")
   `ANUP_ASSERT_SAME(a_overflow_saturates, clock, reset,
      ovf_ff, acc_ff == '1,
      "The accumulator is not saturated after an overflow.")
   `ANUP_ASSERT_NEXT(a_term_clears_parse, clock, reset,
      s1_fire && s1_term,
      phase_ff == PH_SPACE && kw_alive_ff && !sign_ff && !digit_seen_ff && out_valid_ff,
      "The end of a string did not clear the parse state and post a result.")
   `ANUP_ASSERT_SAME(a_term_waits_for_output, clock, reset,
      req_stall, s1_valid_ff && s1_term && out_valid_ff,
      "The input side stalled without a terminator blocked by a full output.")

endmodule
